// File: hw/rtl/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types, command and status codes for the vertex contraction unit.
// ----------------------------------------------------------------------------
package gvc_pkg;

  localparam int MaxVertices = 16;
  localparam int CountW      = 5;

  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_IDENTIFY = 3'd3;
  localparam logic [2:0] CMD_CONTRACT = 3'd4;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_NEXT
  } gvc_rd_sel_e;

  typedef enum logic [2:0] {
    ROW_ZERO,
    ROW_WRITE,
    ROW_READ,
    ROW_A,
    ROW_RESULT
  } gvc_row_sel_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  vertex_a;
    logic [3:0]  vertex_b;
    logic [15:0] row_bits;
    logic [4:0]  new_count;
  } gvc_in_t;

  typedef struct packed {
    logic [15:0] row_out;
    logic [1:0]  status;
    logic [4:0]  vertex_count_out;
  } gvc_out_t;

  typedef struct packed {
    logic         load;
    logic         clear;
    logic         write_row;
    logic         rd_en;
    gvc_rd_sel_e  rd_sel;
    logic         cap_a;
    logic         merge_init;
    logic         walk;
    logic         tail;
    logic         finish;
    logic [1:0]   status;
    gvc_row_sel_e row_sel;
  } gvc_ctrl_t;

  typedef struct packed {
    logic [2:0] command;
    logic       a_ok;
    logic       b_ok;
    logic       merge_ok;
    logic       walk_last;
  } gvc_stat_t;

endpackage

// File: hw/rtl/graph_vertex_contraction_unit.sv
// ----------------------------------------------------------------------------
// graph_vertex_contraction_unit
// Undirected graph store with row access, vertex identify and contract.
// ----------------------------------------------------------------------------
// A transaction is issued by raising start_i with item_i while busy_o is low;
// it is taken at that clock edge and busy_o rises the next cycle. Each
// transaction returns one result on result_o, marked by done_o for exactly
// one cycle; the receiver cannot stall and must take it then. busy_o is low
// during the strobe cycle, so the next transaction may be issued there.
// Steps from the accepting edge to the strobe:
//   clear, write row, range error, unknown command: decode only
//   read row: decode, row read; rejected identify or contract: decode, read
//   of row a, read of row b; identify or contract: as rejected, then the merge
//   walks rows 0 to n-2 one row per cycle for a vertex count n through the row
//   memory (read of the source row and write of the result row overlap), then tail.
// One transaction is handled at a time; a new one is taken once busy_o is low.
// Reset empties the graph at once (per-row valid bits) and sets the count to
// zero; the block is ready right after reset.
// ----------------------------------------------------------------------------
module graph_vertex_contraction_unit #(
  parameter int MAX_VERTICES = gvc_pkg::MaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gvc_pkg::gvc_in_t  item_i,
  output logic              busy_o,
  output gvc_pkg::gvc_out_t result_o,
  output logic              done_o
);

  gvc_pkg::gvc_ctrl_t ctrl;
  gvc_pkg::gvc_stat_t stat;

  gvc_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  gvc_datapath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .result_o(result_o),
    .done_o  (done_o)
  );

endmodule

// File: hw/rtl/gvc_controller.sv
// ----------------------------------------------------------------------------
// gvc_controller
// Command sequencer: decode, row reads, merge walk and result strobe.
// ----------------------------------------------------------------------------
module gvc_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gvc_pkg::gvc_stat_t stat_i,
  output gvc_pkg::gvc_ctrl_t ctrl_o,
  output logic              busy_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_RA     = 3'd3;
  localparam logic [2:0] ST_RB     = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;
  localparam logic [2:0] ST_TAIL   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        case (stat_i.command)
          gvc_pkg::CMD_CLEAR: begin
            ctrl_o.clear   = 1'b1;
            ctrl_o.finish  = 1'b1;
            ctrl_o.status  = gvc_pkg::STATUS_DONE;
            ctrl_o.row_sel = gvc_pkg::ROW_ZERO;
          end
          gvc_pkg::CMD_WRITE: begin
            ctrl_o.finish = 1'b1;
            if (stat_i.a_ok) begin
              ctrl_o.write_row = 1'b1;
              ctrl_o.status    = gvc_pkg::STATUS_DONE;
              ctrl_o.row_sel   = gvc_pkg::ROW_WRITE;
            end else begin
              ctrl_o.status  = gvc_pkg::STATUS_RANGE;
              ctrl_o.row_sel = gvc_pkg::ROW_ZERO;
            end
          end
          gvc_pkg::CMD_READ: begin
            if (stat_i.a_ok) begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = gvc_pkg::RD_A;
              state_d       = ST_READ;
            end else begin
              ctrl_o.finish  = 1'b1;
              ctrl_o.status  = gvc_pkg::STATUS_RANGE;
              ctrl_o.row_sel = gvc_pkg::ROW_ZERO;
            end
          end
          gvc_pkg::CMD_IDENTIFY, gvc_pkg::CMD_CONTRACT: begin
            if (stat_i.a_ok && stat_i.b_ok) begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = gvc_pkg::RD_A;
              state_d       = ST_RA;
            end else begin
              ctrl_o.finish  = 1'b1;
              ctrl_o.status  = gvc_pkg::STATUS_RANGE;
              ctrl_o.row_sel = gvc_pkg::ROW_ZERO;
            end
          end
          default: begin
            ctrl_o.finish  = 1'b1;
            ctrl_o.status  = gvc_pkg::STATUS_REJECT;
            ctrl_o.row_sel = gvc_pkg::ROW_ZERO;
          end
        endcase
      end
      ST_READ: begin
        ctrl_o.finish  = 1'b1;
        ctrl_o.status  = gvc_pkg::STATUS_DONE;
        ctrl_o.row_sel = gvc_pkg::ROW_READ;
        state_d        = ST_IDLE;
      end
      ST_RA: begin
        ctrl_o.cap_a  = 1'b1;
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = gvc_pkg::RD_B;
        state_d       = ST_RB;
      end
      ST_RB: begin
        if (stat_i.merge_ok) begin
          ctrl_o.merge_init = 1'b1;
          ctrl_o.rd_en      = 1'b1;
          ctrl_o.rd_sel     = gvc_pkg::RD_NEXT;
          state_d           = ST_WALK;
        end else begin
          ctrl_o.finish  = 1'b1;
          ctrl_o.status  = gvc_pkg::STATUS_REJECT;
          ctrl_o.row_sel = gvc_pkg::ROW_A;
          state_d        = ST_IDLE;
        end
      end
      ST_WALK: begin
        ctrl_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          state_d = ST_TAIL;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = gvc_pkg::RD_NEXT;
        end
      end
      ST_TAIL: begin
        ctrl_o.tail    = 1'b1;
        ctrl_o.finish  = 1'b1;
        ctrl_o.status  = gvc_pkg::STATUS_DONE;
        ctrl_o.row_sel = gvc_pkg::ROW_RESULT;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == ST_DECODE)
    else $error("load did not lead to decode");

  a_tail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.tail |=> state_q == ST_IDLE && !busy_o)
    else $error("tail did not return to idle");

  a_write_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.write_row |-> ctrl_o.finish && ctrl_o.status == gvc_pkg::STATUS_DONE)
    else $error("row write without completion");

  a_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && !stat_i.walk_last) |=> state_q == ST_WALK)
    else $error("merge walk left early");

endmodule

// File: hw/rtl/gvc_datapath.sv
// ----------------------------------------------------------------------------
// gvc_datapath
// Adjacency row memory, vertex count and merge row arithmetic.
// ----------------------------------------------------------------------------
module gvc_datapath #(
  parameter int MAX_VERTICES = gvc_pkg::MaxVertices
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gvc_pkg::gvc_in_t   item_i,
  input  gvc_pkg::gvc_ctrl_t ctrl_i,
  output gvc_pkg::gvc_stat_t stat_o,
  output gvc_pkg::gvc_out_t  result_o,
  output logic               done_o
);

  localparam int W  = MAX_VERTICES;
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = gvc_pkg::CountW;

  logic [W-1:0]    mem [MAX_VERTICES];
  logic [W-1:0]    valid_q;
  logic [W-1:0]    rd_q, ra_q, merged_q, res_row_q;
  logic            rd_valid_q;
  logic [2:0]      cmd_q;
  logic [3:0]      a_q, b_q;
  logic [15:0]     bits_q;
  logic [CW-1:0]   nc_q, count_q, idx_q;
  logic [15:0]     row_out_q;
  logic [1:0]      status_q;
  logic            done_q;

  logic [W-1:0]    rdata, wr_row, walk_row, merged_row, sel_row;
  logic [CW-1:0]   nxt_k, nxt_src, cur_src, count_dec;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            wr_en;

  function automatic logic [W-1:0] low_mask(input logic [CW-1:0] n);
    logic [W-1:0] m;
    for (int j = 0; j < W; j++) begin
      m[j] = (j < int'(n));
    end
    return m;
  endfunction

  function automatic logic [W-1:0] drop_bit(input logic [W-1:0] row, input logic [3:0] b);
    logic [W-1:0] r;
    for (int j = 0; j < W; j++) begin
      if (j < int'(b)) begin
        r[j] = row[j];
      end else if (j + 1 < W) begin
        r[j] = row[j+1];
      end else begin
        r[j] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] src_of(input logic [CW-1:0] k, input logic [3:0] b);
    return (k < CW'(b)) ? k : k + CW'(1);
  endfunction

  assign rdata     = rd_valid_q ? rd_q : '0;
  assign count_dec = count_q - CW'(1);
  assign nxt_k     = ctrl_i.merge_init ? '0 : idx_q + CW'(1);
  assign nxt_src   = src_of(nxt_k, b_q);
  assign cur_src   = src_of(idx_q, b_q);

  always_comb begin
    case (ctrl_i.rd_sel)
      gvc_pkg::RD_A:    rd_addr = IW'(a_q);
      gvc_pkg::RD_B:    rd_addr = IW'(b_q);
      gvc_pkg::RD_NEXT: rd_addr = IW'(nxt_src);
      default:          rd_addr = IW'(a_q);
    endcase
  end

  assign wr_row = W'(bits_q) & low_mask(count_q);

  always_comb begin
    merged_row = rdata;
    if (merged_q[IW'(cur_src)]) begin
      merged_row = merged_row | (W'(1) << a_q);
    end
    if (cur_src == CW'(a_q)) begin
      merged_row = merged_row | merged_q;
    end
    walk_row = drop_bit(merged_row, b_q) & low_mask(count_dec);
    if (cmd_q == gvc_pkg::CMD_CONTRACT && idx_q == CW'(a_q)) begin
      walk_row = walk_row & ~(W'(1) << a_q);
    end
  end

  assign wr_en   = ctrl_i.write_row || ctrl_i.walk;
  assign wr_addr = ctrl_i.walk ? IW'(idx_q) : IW'(a_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= ctrl_i.walk ? walk_row : wr_row;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= ctrl_i.finish;
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (ctrl_i.clear) begin
        valid_q <= '0;
        count_q <= (int'(nc_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : nc_q;
      end else if (ctrl_i.tail) begin
        valid_q[IW'(count_dec)] <= 1'b0;
        count_q                 <= count_dec;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    case (ctrl_i.row_sel)
      gvc_pkg::ROW_ZERO:   sel_row = '0;
      gvc_pkg::ROW_WRITE:  sel_row = wr_row;
      gvc_pkg::ROW_READ:   sel_row = rdata;
      gvc_pkg::ROW_A:      sel_row = ra_q;
      gvc_pkg::ROW_RESULT: sel_row = res_row_q;
      default:             sel_row = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= item_i.command;
      a_q    <= item_i.vertex_a;
      b_q    <= item_i.vertex_b;
      bits_q <= item_i.row_bits;
      nc_q   <= item_i.new_count;
    end
    if (ctrl_i.cap_a) begin
      ra_q <= rdata;
    end
    if (ctrl_i.merge_init) begin
      merged_q <= (ra_q | rdata) & low_mask(count_q);
      idx_q    <= '0;
    end else if (ctrl_i.walk) begin
      idx_q <= idx_q + CW'(1);
    end
    if (ctrl_i.walk && idx_q == CW'(a_q)) begin
      res_row_q <= walk_row;
    end
    if (ctrl_i.finish) begin
      row_out_q <= 16'(sel_row);
      status_q  <= ctrl_i.status;
    end
  end

  assign stat_o.command   = cmd_q;
  assign stat_o.a_ok      = CW'(a_q) < count_q;
  assign stat_o.b_ok      = CW'(b_q) < count_q;
  assign stat_o.merge_ok  = (a_q < b_q) && ra_q[IW'(b_q)];
  assign stat_o.walk_last = (idx_q == count_q - CW'(2));

  assign result_o.row_out          = row_out_q;
  assign result_o.status           = status_q;
  assign result_o.vertex_count_out = count_q;
  assign done_o                    = done_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MAX_VERTICES)
    else $error("vertex count above capacity");

  a_tail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.tail |=> count_q == $past(count_q) - CW'(1))
    else $error("merge did not drop the count");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(ctrl_i.finish))
    else $error("strobe without completion");

endmodule

// File: sim/tb_graph_vertex_contraction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_vertex_contraction_unit
// Self-checking bench for the vertex contraction unit: a directed pass over
// range errors, rejects, saturation and both merge kinds, then random graphs
// that are written and merged down along real edges, mixed with noise
// commands. A graph model predicts every result.
// ----------------------------------------------------------------------------
module tb_graph_vertex_contraction_unit;
  import gvc_pkg::*;

  localparam logic [2:0] CMD_MAX     = 3'd7;
  localparam int         RandomItems = 1500;
  localparam int         IdlePercent = 14;
  localparam int         DrainCycles = 2 * (MaxVertices + 4);
  localparam int         CycleLimit  = 500000;

  typedef logic [MaxVertices-1:0] row_t;

  class contraction_scoreboard;
    row_t     rows [MaxVertices];
    int       count;
    gvc_out_t pending_results [$];
    int       errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      count  = 0;
      errors = 0;
    endfunction

    function row_t count_mask(int n);
      logic [63:0] m;
      if (n >= MaxVertices) return '1;
      m = (64'd1 << n) - 64'd1;
      return m[MaxVertices-1:0];
    endfunction

    function row_t drop_column(row_t r, int b);
      logic [63:0] w;
      logic [63:0] below;
      logic [63:0] above;
      w     = {{(64-MaxVertices){1'b0}}, r};
      below = w & ((64'd1 << b) - 64'd1);
      above = (w >> (b + 1)) << b;
      w     = below | above;
      return w[MaxVertices-1:0];
    endfunction

    function void merge_into(int a, int b, bit clear_loop);
      int   n;
      row_t merged;
      n      = count;
      merged = (rows[a] | rows[b]) & count_mask(n);
      rows[a] |= merged;
      for (int i = 0; i < n; i++) begin
        if (merged[i]) rows[i][a] = 1'b1;
      end
      for (int i = b; i + 1 < n; i++) rows[i] = rows[i+1];
      rows[n-1] = '0;
      for (int i = 0; i + 1 < n; i++) rows[i] = drop_column(rows[i], b) & count_mask(n - 1);
      if (clear_loop) rows[a][a] = 1'b0;
      count = n - 1;
    endfunction

    function void note_command(gvc_in_t it);
      int         a;
      int         b;
      row_t       row;
      logic [1:0] st;
      gvc_out_t   res;
      a   = it.vertex_a;
      b   = it.vertex_b;
      row = '0;
      st  = STATUS_DONE;
      case (it.command)
        CMD_CLEAR: begin
          foreach (rows[i]) rows[i] = '0;
          count = (it.new_count > MaxVertices) ? MaxVertices : int'(it.new_count);
        end
        CMD_WRITE: begin
          if (a >= count) begin
            st = STATUS_RANGE;
          end else begin
            rows[a] = it.row_bits & count_mask(count);
            row     = rows[a];
          end
        end
        CMD_READ: begin
          if (a >= count) st = STATUS_RANGE;
          else row = rows[a];
        end
        CMD_IDENTIFY, CMD_CONTRACT: begin
          if (a >= count || b >= count) begin
            st = STATUS_RANGE;
          end else if (a >= b || !rows[a][b]) begin
            st  = STATUS_REJECT;
            row = rows[a];
          end else begin
            merge_into(a, b, it.command == CMD_CONTRACT);
            row = rows[a];
          end
        end
        default: begin
          st = STATUS_REJECT;
        end
      endcase
      res.row_out          = row;
      res.status           = st;
      res.vertex_count_out = count[CountW-1:0];
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(gvc_out_t got);
      gvc_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.row_out !== want.row_out)
        report_mismatch($sformatf("row_out %h, expected %h", got.row_out, want.row_out));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.vertex_count_out !== want.vertex_count_out)
        report_mismatch($sformatf("vertex_count_out %0d, expected %0d",
                                  got.vertex_count_out, want.vertex_count_out));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  gvc_in_t   item_i;
  logic      busy_o;
  gvc_out_t  result_o;
  logic      done_o;

  contraction_scoreboard graph_sb = new();
  int        items_sent;
  int        cycle_count;
  bit        gaps_on;

  graph_vertex_contraction_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .result_o (result_o),
    .done_o   (done_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) graph_sb.check_result(result_o);
  end

  function automatic gvc_in_t make_item(logic [2:0] cmd, int a, int b, logic [31:0] bits,
                                        int nc);
    gvc_in_t it;
    it.command   = cmd;
    it.vertex_a  = a[3:0];
    it.vertex_b  = b[3:0];
    it.row_bits  = bits[15:0];
    it.new_count = nc[4:0];
    return it;
  endfunction

  task automatic send_command(gvc_in_t it);
    while (gaps_on && $urandom_range(0, 99) < IdlePercent) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    graph_sb.note_command(it);
    if (it.command <= CMD_CONTRACT) items_sent++;
  endtask

  function automatic bit pick_edge(output int a, output int b);
    int pairs;
    int k;
    pairs = 0;
    a     = 0;
    b     = 0;
    for (int i = 0; i < graph_sb.count; i++)
      for (int j = i + 1; j < graph_sb.count; j++)
        if (graph_sb.rows[i][j]) pairs++;
    if (pairs == 0) return 1'b0;
    k = $urandom_range(0, pairs - 1);
    for (int i = 0; i < graph_sb.count; i++)
      for (int j = i + 1; j < graph_sb.count; j++)
        if (graph_sb.rows[i][j]) begin
          if (k == 0) begin
            a = i;
            b = j;
            return 1'b1;
          end
          k--;
        end
    return 1'b0;
  endfunction

  function automatic int pick_vertex();
    if (graph_sb.count > 0 && $urandom_range(0, 1) == 1)
      return $urandom_range(0, graph_sb.count - 1);
    return $urandom_range(0, 15);
  endfunction

  task automatic send_noise();
    int cmd;
    if ($urandom_range(0, 99) < 5) cmd = CMD_CLEAR;
    else cmd = $urandom_range(CMD_WRITE, CMD_MAX);
    send_command(make_item(cmd[2:0], pick_vertex(), pick_vertex(), $urandom,
                           $urandom_range(0, 31)));
  endtask

  task automatic run_graph();
    row_t        adj [MaxVertices];
    logic [31:0] noise;
    int          n;
    int          density;
    int          limit;
    int          a;
    int          b;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 31);
    else n = $urandom_range(2, MaxVertices);
    send_command(make_item(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                           n));
    n       = graph_sb.count;
    density = $urandom_range(10, 90);
    foreach (adj[i]) adj[i] = '0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) adj[i][i] = 1'b1;
      for (int j = i + 1; j < n; j++)
        if ($urandom_range(0, 99) < density) begin
          adj[i][j] = 1'b1;
          adj[j][i] = 1'b1;
        end
    end
    for (int i = 0; i < n; i++) begin
      noise = $urandom;
      send_command(make_item(CMD_WRITE, i, $urandom_range(0, 15),
                             {16'b0, adj[i] | (noise[15:0] & ~graph_sb.count_mask(n))},
                             $urandom_range(0, 31)));
    end
    limit = n + $urandom_range(0, 6);
    for (int ops = 0; ops < limit; ops++) begin
      if ($urandom_range(0, 99) < 75 && pick_edge(a, b))
        send_command(make_item($urandom_range(0, 1) ? CMD_IDENTIFY : CMD_CONTRACT, a, b,
                               $urandom, $urandom_range(0, 31)));
      else
        send_noise();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    items_sent  = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(make_item(CMD_READ, 0, 0, 0, 0));
    send_command(make_item(CMD_CLEAR, 15, 15, 32'hFFFF, 31));
    send_command(make_item(CMD_WRITE, 15, 0, 32'hFFFF, 0));
    send_command(make_item(CMD_WRITE, 0, 15, 32'hFFFF, 0));
    send_command(make_item(CMD_READ, 15, 0, 0, 0));
    send_command(make_item(CMD_READ, 0, 0, 0, 0));
    send_command(make_item(CMD_IDENTIFY, 0, 15, 0, 0));
    send_command(make_item(CMD_CONTRACT, 3, 3, 0, 0));
    send_command(make_item(CMD_CONTRACT, 5, 2, 0, 0));
    send_command(make_item(CMD_WRITE, 1, 0, 0, 0));
    send_command(make_item(CMD_CONTRACT, 1, 2, 0, 0));
    send_command(make_item(CMD_CONTRACT, 0, 1, 0, 0));
    send_command(make_item(CMD_WRITE, 14, 0, 32'hFFFF, 0));
    send_command(make_item(CMD_IDENTIFY, 0, 14, 0, 0));
    for (int c = CMD_CONTRACT + 1; c <= CMD_MAX; c++)
      send_command(make_item(c[2:0], 0, 1, 32'hFFFF, 0));
    send_command(make_item(CMD_CLEAR, 0, 0, 0, 0));
    send_command(make_item(CMD_WRITE, 0, 0, 32'hFFFF, 0));
    send_command(make_item(CMD_CLEAR, 0, 0, 0, 2));
    send_command(make_item(CMD_WRITE, 0, 0, 32'hFFFF, 0));
    send_command(make_item(CMD_WRITE, 1, 0, 32'h0001, 0));
    send_command(make_item(CMD_IDENTIFY, 0, 1, 0, 0));
    send_command(make_item(CMD_READ, 0, 0, 0, 0));

    items_sent = 0;
    while (items_sent < RandomItems) begin
      // hold the sender busy through the middle of the run
      gaps_on = !(items_sent >= RandomItems / 3 && items_sent < RandomItems / 2);
      run_graph();
    end
    start_i <= 1'b0;

    while (graph_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (graph_sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
